/* hw/rtl/tspsr_pkg.sv */
// shared types and constants of the transport stream stuffing rewriter
package tspsr_pkg;

  // packet treatment codes
  localparam logic [1:0] CMD_PASS = 2'd0;
  localparam logic [1:0] CMD_HEAD = 2'd1;
  localparam logic [1:0] CMD_TAIL = 2'd2;

  localparam logic [7:0] SYNC_BYTE  = 8'h47;
  localparam logic [7:0] STUFF_BYTE = 8'hFF;

  // adaptation field control values
  localparam logic [1:0] AFC_ADAPT = 2'b10;
  localparam logic [1:0] AFC_BOTH  = 2'b11;

  // continuity counter increments
  localparam logic [3:0] CC_HEAD_ADD = 4'd5;
  localparam logic [3:0] CC_TAIL_ADD = 4'd3;

  // byte positions inside the packet header
  localparam int unsigned POS_PUSI     = 1;
  localparam int unsigned POS_AFC      = 3;
  localparam int unsigned POS_AF_LEN   = 4;
  localparam int unsigned POS_AF_FLAGS = 5;
  localparam int unsigned POS_AF_DATA  = 6;
  localparam int unsigned HDR_BYTES    = 4;

  localparam int unsigned HEAD_MIN_AMOUNT = 5;

  // result queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPW         = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW         = QPW + 1;

  // classified beat: either an immediate byte or a byte fetched from the store
  typedef struct packed {
    logic       fetch;
    logic [7:0] imm;
    logic       last;
    logic       sync_error;
  } tspsr_op_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       sync_error;
  } tspsr_item_t;

  typedef struct packed {
    logic           full;
    logic [QCW-1:0] count;
  } tspsr_qstat_t;

endpackage

/* hw/rtl/tspsr_ram.sv */
// generic single write port ram with registered read
module tspsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 188,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/tspsr_front.sv */
// front part: byte position, header capture, classification and store access
module tspsr_front #(
  parameter int PACKET_BYTES = 188,
  localparam int PW = $clog2(PACKET_BYTES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_byte,
  input  logic [7:0]          in_amount,
  input  logic                q_full,
  output logic                in_full,
  output logic                ram_we,
  output logic [PW-1:0]       ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic                ram_re,
  output logic [PW-1:0]       ram_raddr,
  output logic                op_vld,
  output tspsr_pkg::tspsr_op_t op
);

  logic                 acc;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [1:0]           cmd_r, cmd_nxt;
  logic [PW-1:0]        amt_r, amt_nxt;
  logic                 sync_r, sync_nxt;
  logic                 us_r, us_nxt;
  logic [1:0]           ctrl_r, ctrl_nxt;
  logic [7:0]           len_r, len_nxt;
  tspsr_pkg::tspsr_op_t op_r, op_nxt;
  logic                 op_vld_r;

  logic                 is_first;
  logic                 is_last;
  logic                 sync_e;
  logic [7:0]           len_e;
  logic [PW-1:0]        amt_sat;
  logic                 head_go;
  logic                 tail_go;
  logic                 pad;
  logic [PW-1:0]        e_pad;
  logic [PW-1:0]        e_np;
  logic [PW-1:0]        e;
  logic [PW:0]          lim;
  logic                 fetch_hit;
  logic [1:0]           tail_afc;

  assign acc       = in_push && !q_full;
  assign in_full   = q_full;
  assign ram_we    = acc;
  assign ram_re    = acc;
  assign ram_waddr = pos_r;
  assign ram_wdata = in_byte;
  assign ram_raddr = pos_r - e;
  assign op_vld    = op_vld_r;
  assign op        = op_r;

  assign is_first = (pos_r == '0);
  assign is_last  = (pos_r == PW'(PACKET_BYTES - 1));
  assign amt_sat  = (in_amount > 8'(PACKET_BYTES - 1)) ? PW'(PACKET_BYTES - 1)
                                                       : PW'(in_amount);
  assign sync_e   = is_first ? (in_byte == tspsr_pkg::SYNC_BYTE) : sync_r;
  assign len_e    = (pos_r == PW'(tspsr_pkg::POS_AF_LEN)) ? in_byte : len_r;

  // header state
  always_comb begin
    pos_nxt  = pos_r;
    cmd_nxt  = cmd_r;
    amt_nxt  = amt_r;
    sync_nxt = sync_r;
    us_nxt   = us_r;
    ctrl_nxt = ctrl_r;
    len_nxt  = len_r;
    if (acc) begin
      pos_nxt = is_last ? '0 : pos_r + 1'b1;
      if (is_first) begin
        cmd_nxt  = in_cmd;
        amt_nxt  = amt_sat;
        sync_nxt = sync_e;
      end
      if (pos_r == PW'(tspsr_pkg::POS_PUSI)) begin
        us_nxt = in_byte[6];
      end
      if (pos_r == PW'(tspsr_pkg::POS_AFC)) begin
        ctrl_nxt = in_byte[5:4];
      end
      if (pos_r == PW'(tspsr_pkg::POS_AF_LEN)) begin
        len_nxt = in_byte;
      end
    end
  end

  // classification of the current beat
  always_comb begin
    head_go = sync_r && (cmd_r == tspsr_pkg::CMD_HEAD)
              && (amt_r >= PW'(tspsr_pkg::HEAD_MIN_AMOUNT)) && !us_r;
    tail_go = sync_r && (cmd_r == tspsr_pkg::CMD_TAIL) && (amt_r != '0);
    pad     = ctrl_r[1] && (len_e != 8'h00);
    e_pad   = (amt_r > PW'(PACKET_BYTES - 6)) ? PW'(PACKET_BYTES - 6) : amt_r;
    e_np    = (amt_r > PW'(PACKET_BYTES - 4)) ? PW'(PACKET_BYTES - 4) : amt_r;
    e       = pad ? e_pad : e_np;
    lim     = {1'b0, e} + (pad ? (PW+1)'(tspsr_pkg::POS_AF_DATA)
                               : (PW+1)'(tspsr_pkg::HDR_BYTES));
    fetch_hit = ({1'b0, pos_r} >= lim);
    tail_afc  = (amt_r == PW'(PACKET_BYTES - 4)) ? tspsr_pkg::AFC_ADAPT
                                                 : tspsr_pkg::AFC_BOTH;

    op_nxt.fetch      = 1'b0;
    op_nxt.imm        = in_byte;
    op_nxt.last       = is_last;
    op_nxt.sync_error = !sync_e;

    if (head_go) begin
      if (pos_r == PW'(tspsr_pkg::POS_AFC)) begin
        op_nxt.imm = {in_byte[7:6], tspsr_pkg::AFC_BOTH,
                      in_byte[3:0] + tspsr_pkg::CC_HEAD_ADD};
      end else if (pos_r == PW'(tspsr_pkg::POS_AF_LEN)) begin
        op_nxt.imm = 8'(amt_r - PW'(tspsr_pkg::HEAD_MIN_AMOUNT));
      end else if (pos_r == PW'(tspsr_pkg::POS_AF_FLAGS)) begin
        // empty flags byte only when a fresh field is opened
        if (amt_r > PW'(tspsr_pkg::HEAD_MIN_AMOUNT) && !ctrl_r[1]) begin
          op_nxt.imm = 8'h00;
        end
      end else if (pos_r >= PW'(tspsr_pkg::POS_AF_DATA) && pos_r < amt_r) begin
        op_nxt.imm = tspsr_pkg::STUFF_BYTE;
      end
    end else if (tail_go) begin
      if (pos_r == PW'(tspsr_pkg::POS_AFC)) begin
        op_nxt.imm = {in_byte[7:6], tail_afc,
                      in_byte[3:0] + tspsr_pkg::CC_TAIL_ADD};
      end else if (pos_r >= PW'(tspsr_pkg::HDR_BYTES)) begin
        if (fetch_hit) begin
          op_nxt.fetch = 1'b1;
        end else if (pos_r == PW'(tspsr_pkg::POS_AF_LEN)) begin
          op_nxt.imm = pad ? in_byte + 8'(e) : 8'(e - 1'b1);
        end else if (pos_r == PW'(tspsr_pkg::POS_AF_FLAGS)) begin
          op_nxt.imm = pad ? in_byte : 8'h00;
        end else begin
          op_nxt.imm = tspsr_pkg::STUFF_BYTE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      cmd_r    <= tspsr_pkg::CMD_PASS;
      amt_r    <= '0;
      sync_r   <= 1'b0;
      us_r     <= 1'b0;
      ctrl_r   <= '0;
      len_r    <= '0;
      op_vld_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      cmd_r    <= cmd_nxt;
      amt_r    <= amt_nxt;
      sync_r   <= sync_nxt;
      us_r     <= us_nxt;
      ctrl_r   <= ctrl_nxt;
      len_r    <= len_nxt;
      op_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r <= op_nxt;
    end
  end

endmodule

/* hw/rtl/tspsr_back.sv */
// back part: resolves fetched bytes and queues results toward the receiver
module tspsr_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    op_vld,
  input  tspsr_pkg::tspsr_op_t    op,
  input  logic [7:0]              fetch_data,
  input  logic                    out_pop,
  output logic                    out_empty,
  output logic [7:0]              out_byte,
  output logic                    out_last,
  output logic                    out_sync_error,
  output tspsr_pkg::tspsr_qstat_t qstat
);

  localparam int QPW = tspsr_pkg::QPW;
  localparam int QCW = tspsr_pkg::QCW;

  tspsr_pkg::tspsr_item_t mem_r [tspsr_pkg::QUEUE_DEPTH];
  tspsr_pkg::tspsr_item_t item;
  tspsr_pkg::tspsr_item_t head;
  logic [QPW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]         count_r, count_nxt;
  logic                   pop;
  logic [QCW:0]           occupancy;

  assign item.out_byte   = op.fetch ? fetch_data : op.imm;
  assign item.last       = op.last;
  assign item.sync_error = op.sync_error;

  assign pop  = out_pop && (count_r != '0);
  assign head = mem_r[rd_ptr_r];

  // the beat in the stage register is counted so it always finds room
  assign occupancy   = (QCW+1)'(count_r) + (QCW+1)'(op_vld);
  assign qstat.full  = (occupancy >= (QCW+1)'(tspsr_pkg::QUEUE_DEPTH));
  assign qstat.count = count_r;

  assign out_empty      = (count_r == '0);
  assign out_byte       = head.out_byte;
  assign out_last       = head.last;
  assign out_sync_error = head.sync_error;

  always_comb begin
    wr_ptr_nxt = op_vld ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCW'(op_vld) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_vld) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

/* hw/rtl/ts_packet_stuffing_rewriter.sv */
// Transport stream packet rewriter: turns unwanted bytes into stuffing.
// Input side is a queue: a beat (in_cmd, in_byte, in_amount) is taken when
// in_push is high and in_full is low. Packets of PACKET_BYTES bytes arrive in
// order from the sync byte; in_cmd and in_amount count only on the first byte.
// Result side is a queue too: while out_empty is low the oldest rewritten byte
// stands on out_byte, out_last, out_sync_error and leaves on out_pop.
// Every input beat gives exactly one result beat at the same packet position.
// A byte taken is held in the classification stage register while the packet
// store is read, then written into the result queue, from which it can be popped.
// Throughput: one byte per clock while in_full is low; the packet store has a
// read port beside its write port; tail stuffing reads bytes stored earlier.
// When the receiver stalls, a four-entry result queue fills and in_full rises
// once the queue and the stage register hold four beats; nothing is dropped.
// Reset clears the byte position, the captured header fields and the queue;
// the packet store is not cleared, since it is only read after being written
// in the same packet.
module ts_packet_stuffing_rewriter #(
  parameter int PACKET_BYTES = 188
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_byte,
  input  logic [7:0] in_amount,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_sync_error
);

  localparam int PW = $clog2(PACKET_BYTES);

  logic                    ram_we;
  logic [PW-1:0]           ram_waddr;
  logic [7:0]              ram_wdata;
  logic                    ram_re;
  logic [PW-1:0]           ram_raddr;
  logic [7:0]              ram_rdata;
  logic                    op_vld;
  tspsr_pkg::tspsr_op_t    op;
  tspsr_pkg::tspsr_qstat_t qstat;

  tspsr_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_cmd    (in_cmd),
    .in_byte   (in_byte),
    .in_amount (in_amount),
    .q_full    (qstat.full),
    .in_full   (in_full),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .op_vld    (op_vld),
    .op        (op)
  );

  tspsr_ram #(
    .WIDTH(8),
    .DEPTH(PACKET_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tspsr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_vld         (op_vld),
    .op             (op),
    .fetch_data     (ram_rdata),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_sync_error (out_sync_error),
    .qstat          (qstat)
  );

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  // every accepted beat reaches the stage register on the next edge
  a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> op_vld)
    else $error("accepted beat lost before the result queue");

  // the stage register never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    op_vld |-> (qstat.count < tspsr_pkg::QCW'(tspsr_pkg::QUEUE_DEPTH)))
    else $error("result queue overflow");

endmodule
